/* rtl/tbnf_pkg.sv */
// Shared constants and status codes for the touch burst noise filter.
`default_nettype none

package tbnf_pkg;

    localparam int TBNF_SAMPLE_BITS = 12;

    localparam int BURST_LEN   = 9;
    localparam int GROUP_LEN   = 3;
    localparam int GROUP_COUNT = 3;
    localparam int CNT_BITS    = 4;
    localparam int GRP_BITS    = 2;

    localparam int THRESH_BITS = 12;
    localparam int POS_BITS    = 12;
    localparam int STATUS_BITS = 2;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOISE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_ABORT = 2'd2;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_NOISE_THRESHOLD = 1'b0;

endpackage

`default_nettype wire

/* rtl/tbnf_axis.sv */
// Closest-pair selection and noise test for the three group averages of one axis.
`default_nettype none

module tbnf_axis
    import tbnf_pkg::*;
#(
    parameter int SAMPLE_BITS = TBNF_SAMPLE_BITS
) (
    input  wire logic [SAMPLE_BITS-1:0] i_avg0,
    input  wire logic [SAMPLE_BITS-1:0] i_avg1,
    input  wire logic [SAMPLE_BITS-1:0] i_avg2,
    input  wire logic [THRESH_BITS-1:0] i_threshold,
    output logic                        o_noise,
    output logic [POS_BITS-1:0]         o_position
);

    localparam int CMP_W = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS :
                           ((THRESH_BITS > POS_BITS) ? THRESH_BITS : POS_BITS);

    logic [SAMPLE_BITS-1:0] d01;
    logic [SAMPLE_BITS-1:0] d12;
    logic [SAMPLE_BITS-1:0] d20;
    logic [CMP_W-1:0]       thr;
    logic [SAMPLE_BITS-1:0] sel_a;
    logic [SAMPLE_BITS-1:0] sel_b;
    logic [SAMPLE_BITS:0]   pair_sum;
    logic [CMP_W-1:0]       pos_ext;

    always_comb begin
        d01 = (i_avg0 > i_avg1) ? (i_avg0 - i_avg1) : (i_avg1 - i_avg0);
        d12 = (i_avg1 > i_avg2) ? (i_avg1 - i_avg2) : (i_avg2 - i_avg1);
        d20 = (i_avg2 > i_avg0) ? (i_avg2 - i_avg0) : (i_avg0 - i_avg2);
        thr = CMP_W'(i_threshold);

        o_noise = (CMP_W'(d01) > thr) && (CMP_W'(d12) > thr) && (CMP_W'(d20) > thr);

        if (d01 < d12) begin
            sel_a = i_avg0;
            sel_b = (d20 < d01) ? i_avg2 : i_avg1;
        end else begin
            sel_a = (d20 < d12) ? i_avg0 : i_avg1;
            sel_b = i_avg2;
        end

        pair_sum   = {1'b0, sel_a} + {1'b0, sel_b};
        pos_ext    = CMP_W'(pair_sum[SAMPLE_BITS:1]);
        o_position = pos_ext[POS_BITS-1:0];
    end

endmodule

`default_nettype wire

/* rtl/touch_burst_noise_filter_top.sv */
// Top level of the touch burst noise filter: burst accumulation, averaging and result register.
`default_nettype none

// The block takes one X/Y sample beat per clock while o_stall is low and emits one result per
// burst: after the ninth beat (status accepted or noise) or on the first beat whose pen_down
// is 0 before that (status aborted, positions 0). The beat that ends the burst passes in
// order through the input register, group-sum register, group-average register (a
// multiply by the reciprocal of three) and result register. Each stage moves on when the
// one after it is empty or moving, so a waiting result does not block input beats
// until all stages are full. The noise threshold is written over the APB port at
// byte address 0 and should only be changed while no burst is in flight.
module touch_burst_noise_filter_top
    import tbnf_pkg::*;
#(
    parameter int SAMPLE_BITS = TBNF_SAMPLE_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [SAMPLE_BITS-1:0]   i_x_sample,
    input  wire logic [SAMPLE_BITS-1:0]   i_y_sample,
    input  wire logic                     i_pen_down,

    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [POS_BITS-1:0]           o_x_position,
    output logic [POS_BITS-1:0]           o_y_position,
    output logic [STATUS_BITS-1:0]        o_status,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int DIV_K  = SUM_W + 2;
    localparam int DIV_M  = ((1 << DIV_K) + 2) / 3;
    localparam int PROD_W = SUM_W + DIV_K;

    logic [THRESH_BITS-1:0] r_threshold;
    logic                   cfg_write;

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_x;
    logic [SAMPLE_BITS-1:0] r_in_y;
    logic                   r_in_pen;

    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    n_count;
    logic [GRP_BITS-1:0]    grp;
    logic [SUM_W-1:0]       r_sum_x [GROUP_COUNT];
    logic [SUM_W-1:0]       r_sum_y [GROUP_COUNT];
    logic [SUM_W-1:0]       n_sum_x [GROUP_COUNT];
    logic [SUM_W-1:0]       n_sum_y [GROUP_COUNT];

    logic                   r_fin_valid;
    logic                   r_fin_abort;
    logic [SUM_W-1:0]       r_fin_x [GROUP_COUNT];
    logic [SUM_W-1:0]       r_fin_y [GROUP_COUNT];

    logic                   r_avg_valid;
    logic                   r_avg_abort;
    logic [SAMPLE_BITS-1:0] r_avg_x [GROUP_COUNT];
    logic [SAMPLE_BITS-1:0] r_avg_y [GROUP_COUNT];
    logic [SAMPLE_BITS-1:0] n_avg_x [GROUP_COUNT];
    logic [SAMPLE_BITS-1:0] n_avg_y [GROUP_COUNT];
    logic [PROD_W-1:0]      prod_x  [GROUP_COUNT];
    logic [PROD_W-1:0]      prod_y  [GROUP_COUNT];

    logic                   r_out_valid;
    logic [POS_BITS-1:0]    r_out_x;
    logic [POS_BITS-1:0]    r_out_y;
    logic [STATUS_BITS-1:0] r_out_status;

    logic                   noise_x;
    logic                   noise_y;
    logic [POS_BITS-1:0]    pos_x;
    logic [POS_BITS-1:0]    pos_y;

    logic                   out_en;
    logic                   avg_en;
    logic                   avg_go;
    logic                   fin_en;
    logic                   fin_go;
    logic                   in_end;
    logic                   in_full;
    logic                   in_go;
    logic                   in_en;
    logic                   accept;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_NOISE_THRESHOLD) ? APB_DATA_BITS'(r_threshold)
                                                          : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (cfg_write && (paddr[2] == REG_NOISE_THRESHOLD)) begin
            r_threshold <= pwdata[THRESH_BITS-1:0];
        end
    end

    always_comb begin
        out_en  = !r_out_valid || !i_stall;
        avg_go  = r_avg_valid && out_en;
        avg_en  = !r_avg_valid || out_en;
        fin_go  = r_fin_valid && avg_en;
        fin_en  = !r_fin_valid || avg_en;

        n_count = r_count + CNT_BITS'(1);
        in_full = (n_count == CNT_BITS'(BURST_LEN));
        in_end  = in_full || !r_in_pen;
        in_go   = r_in_valid && (!in_end || fin_en);
        in_en   = !r_in_valid || in_go;
        accept  = i_valid && in_en;
        o_stall = !in_en;

        if (r_count < CNT_BITS'(GROUP_LEN)) begin
            grp = GRP_BITS'(0);
        end else if (r_count < CNT_BITS'(2 * GROUP_LEN)) begin
            grp = GRP_BITS'(1);
        end else begin
            grp = GRP_BITS'(2);
        end

        for (int g = 0; g < GROUP_COUNT; g++) begin
            n_sum_x[g] = r_sum_x[g] + ((grp == GRP_BITS'(g)) ? SUM_W'(r_in_x) : '0);
            n_sum_y[g] = r_sum_y[g] + ((grp == GRP_BITS'(g)) ? SUM_W'(r_in_y) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (in_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_x   <= i_x_sample;
            r_in_y   <= i_y_sample;
            r_in_pen <= i_pen_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_sum_x[g] <= '0;
                r_sum_y[g] <= '0;
            end
        end else if (in_go) begin
            if (in_end) begin
                r_count <= '0;
                for (int g = 0; g < GROUP_COUNT; g++) begin
                    r_sum_x[g] <= '0;
                    r_sum_y[g] <= '0;
                end
            end else begin
                r_count <= n_count;
                for (int g = 0; g < GROUP_COUNT; g++) begin
                    r_sum_x[g] <= n_sum_x[g];
                    r_sum_y[g] <= n_sum_y[g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (in_go && in_end) begin
            r_fin_valid <= 1'b1;
        end else if (fin_go) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go && in_end) begin
            r_fin_abort <= !in_full;
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_fin_x[g] <= n_sum_x[g];
                r_fin_y[g] <= n_sum_y[g];
            end
        end
    end

    always_comb begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            prod_x[g]  = PROD_W'(r_fin_x[g]) * PROD_W'(DIV_M);
            prod_y[g]  = PROD_W'(r_fin_y[g]) * PROD_W'(DIV_M);
            n_avg_x[g] = prod_x[g][DIV_K +: SAMPLE_BITS];
            n_avg_y[g] = prod_y[g][DIV_K +: SAMPLE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_valid <= 1'b0;
        end else if (fin_go) begin
            r_avg_valid <= 1'b1;
        end else if (avg_go) begin
            r_avg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_avg_abort <= r_fin_abort;
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_avg_x[g] <= n_avg_x[g];
                r_avg_y[g] <= n_avg_y[g];
            end
        end
    end

    tbnf_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_x (
        .i_avg0      (r_avg_x[0]),
        .i_avg1      (r_avg_x[1]),
        .i_avg2      (r_avg_x[2]),
        .i_threshold (r_threshold),
        .o_noise     (noise_x),
        .o_position  (pos_x)
    );

    tbnf_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_y (
        .i_avg0      (r_avg_y[0]),
        .i_avg1      (r_avg_y[1]),
        .i_avg2      (r_avg_y[2]),
        .i_threshold (r_threshold),
        .o_noise     (noise_y),
        .o_position  (pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (avg_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (avg_go) begin
            if (r_avg_abort) begin
                r_out_x      <= '0;
                r_out_y      <= '0;
                r_out_status <= ST_ABORT;
            end else if (noise_x || noise_y) begin
                r_out_x      <= '0;
                r_out_y      <= '0;
                r_out_status <= ST_NOISE;
            end else begin
                r_out_x      <= pos_x;
                r_out_y      <= pos_y;
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_x_position = r_out_x;
    assign o_y_position = r_out_y;
    assign o_status     = r_out_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_BITS'(BURST_LEN))
        else $error("Burst beat count left its range.");

    a_burst_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_go && in_end) |=> (r_count == '0) && (r_sum_x[0] == '0) && (r_sum_y[0] == '0))
        else $error("Burst state was not cleared after a result.");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_x_position == '0) && (o_y_position == '0))
        else $error("Rejected or aborted result carries a position.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_NOISE) || (o_status == ST_ABORT))
        else $error("Result status code out of range.");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_fin_valid && r_avg_valid && r_out_valid && i_stall)
        else $error("Input stalled while the pipeline had room.");

endmodule

`default_nettype wire
